>>> hw/rtl/mi3_pkg.sv
// ============================================================================
// mi3_pkg: shared types and constants for the 3x3 matrix inverse
// Widths of the fixed-point datapath, the cofactor index tables and the
// word that travels down each divider lane.
// ============================================================================
package mi3_pkg;

    localparam int ELEM_W  = 16;   // Q8.8 input element
    localparam int OUT_W   = 32;   // Q16.16 result element
    localparam int PROD_W  = 32;   // product of two elements
    localparam int ADJ_W   = 33;   // cofactor, difference of two products
    localparam int DP_W    = 49;   // element times cofactor
    localparam int DET_W   = 51;   // determinant sum, Q27.24
    localparam int MAG_W   = 32;   // cofactor magnitude
    localparam int TOL_W   = 47;   // tolerance, Q31.16
    localparam int CMP_W   = TOL_W + 8;
    localparam int FRAC_SH = 24;   // numerator is |adj| shifted by this
    localparam int QB      = 33;   // quotient bits produced by the lanes
    localparam int PRE_SH  = QB - FRAC_SH;            // 9
    localparam int TOP_W   = MAG_W - PRE_SH;          // 23
    localparam int NELEM   = 9;
    localparam int FRONT   = 5;                       // stages before the lanes
    localparam int LAT     = FRONT + QB + 1;          // total register stages

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

    // Cofactor i = a[PA_L[i]] * a[PA_R[i]] - a[PB_L[i]] * a[PB_R[i]].
    localparam int PA_L [NELEM] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int PA_R [NELEM] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int PB_L [NELEM] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int PB_R [NELEM] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

    typedef struct packed {
        logic [MAG_W-1:0]         mag;   // |cofactor|
        logic                     neg;   // sign of the quotient
        logic [DET_W-1:0]         den;   // |determinant|
        logic                     ovf;   // quotient certainly saturates
        logic                     sing;  // matrix treated as singular
        logic signed [ELEM_W-1:0] pass;  // input element for pass-through
    } mi3_lane_t;

endpackage

>>> hw/rtl/mi3_div_lane.sv
// ============================================================================
// mi3_div_lane: pipelined restoring divider for one result element
// Produces one quotient bit per stage, then rounds, saturates and selects
// the pass-through value in a final output register.
// ============================================================================
module mi3_div_lane
    import mi3_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  mi3_lane_t                lane_in,
    output logic signed [OUT_W-1:0]  r,
    output logic                     inv
);

    logic [DET_W-1:0] rem_reg  [1:QB];
    logic [QB-1:0]    q_reg    [1:QB];
    mi3_lane_t        side_reg [1:QB];

    genvar k;
    generate
        for (k = 0; k < QB; k++)
        begin : g_stage
            localparam int B = QB - 1 - k;
            mi3_lane_t        side_c;
            logic [DET_W-1:0] rem_c;
            logic [QB-1:0]    q_c;
            logic             nbit;
            logic [DET_W:0]   trial;
            logic             ge;

            if (k == 0)
            begin : g_first
                assign side_c = lane_in;
                assign rem_c  = {{(DET_W-TOP_W){1'b0}}, lane_in.mag[MAG_W-1:PRE_SH]};
                assign q_c    = '0;
            end
            else
            begin : g_rest
                assign side_c = side_reg[k];
                assign rem_c  = rem_reg[k];
                assign q_c    = q_reg[k];
            end

            if (B >= FRAC_SH)
            begin : g_numbit
                assign nbit = side_c.mag[B-FRAC_SH];
            end
            else
            begin : g_zerobit
                assign nbit = 1'b0;
            end

            assign trial = {rem_c, nbit};
            assign ge    = trial >= {1'b0, side_c.den};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k+1]  <= ge ? DET_W'(trial - {1'b0, side_c.den})
                                        : DET_W'(trial);
                    q_reg[k+1]    <= {q_c[QB-2:0], ge};
                    side_reg[k+1] <= side_c;
                end
            end
        end
    endgenerate

    // Round to nearest, ties away from zero: add one when twice the
    // remainder reaches the divisor.
    logic                    rnd;
    logic [QB:0]             qr;
    logic                    sat;
    mi3_lane_t               last;
    logic signed [OUT_W-1:0] r_next;
    logic signed [OUT_W-1:0] r_reg;
    logic                    inv_reg;

    assign last = side_reg[QB];
    assign rnd  = {rem_reg[QB], 1'b0} >= {1'b0, last.den};
    assign qr   = {1'b0, q_reg[QB]} + (QB+1)'(rnd);
    assign sat  = last.ovf || (qr[QB:OUT_W-1] != '0);

    always_comb
    begin
        if (last.sing)
            r_next = {{(OUT_W-ELEM_W-8){last.pass[ELEM_W-1]}}, last.pass, 8'h00};
        else if (sat)
            r_next = last.neg ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
        else if (last.neg)
            r_next = OUT_W'(0) - {1'b0, qr[OUT_W-2:0]};
        else
            r_next = {1'b0, qr[OUT_W-2:0]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg   <= r_next;
            inv_reg <= !last.sing;
        end
    end

    assign r   = r_reg;
    assign inv = inv_reg;

endmodule

>>> hw/rtl/matrix3x3_inverse_top.sv
// ============================================================================
// matrix3x3_inverse_top: 3x3 inverse by the adjugate, Q8.8 in, Q16.16 out
// Cofactors and determinant in a five-stage front end, then nine
// bit-per-stage divider lanes that share one stall enable.
// ============================================================================
// Throughput: one matrix per cycle while the result word is not stalled;
// each of the nine divider lanes is a 33-stage pipeline producing one
// quotient bit per stage.
// The whole pipeline advances together and holds when the output word is
// stalled. Reset clears the valid bits and sets the tolerance to one LSB.
module matrix3x3_inverse_top
    import mi3_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // input word
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [ELEM_W-1:0] a_00,
    input  logic signed [ELEM_W-1:0] a_01,
    input  logic signed [ELEM_W-1:0] a_02,
    input  logic signed [ELEM_W-1:0] a_10,
    input  logic signed [ELEM_W-1:0] a_11,
    input  logic signed [ELEM_W-1:0] a_12,
    input  logic signed [ELEM_W-1:0] a_20,
    input  logic signed [ELEM_W-1:0] a_21,
    input  logic signed [ELEM_W-1:0] a_22,
    // result word
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [OUT_W-1:0]  r_00,
    output logic signed [OUT_W-1:0]  r_01,
    output logic signed [OUT_W-1:0]  r_02,
    output logic signed [OUT_W-1:0]  r_10,
    output logic signed [OUT_W-1:0]  r_11,
    output logic signed [OUT_W-1:0]  r_12,
    output logic signed [OUT_W-1:0]  r_20,
    output logic signed [OUT_W-1:0]  r_21,
    output logic signed [OUT_W-1:0]  r_22,
    output logic                     invertible,
    // tolerance write
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [TOL_W-1:0]         cfg_data
);

    // The pipeline moves whenever the output register is empty or being
    // taken, so a new word is accepted in the same cycle a result leaves.
    logic en;
    logic vld_reg [0:LAT-1];

    assign en        = !vld_reg[LAT-1] || !out_stall;
    assign in_stall  = !en;
    assign out_valid = vld_reg[LAT-1];
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < LAT; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    // Singular tolerance, Q31.16.
    logic [TOL_W-1:0] tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= TOL_RESET;
        else if (cfg_valid && cfg_ready)
            tol_reg <= cfg_data;
    end

    logic signed [ELEM_W-1:0] a_w [NELEM];

    assign a_w = '{a_00, a_01, a_02, a_10, a_11, a_12, a_20, a_21, a_22};

    // Stage 1: the eighteen element products behind the cofactors.
    logic signed [PROD_W-1:0] pa_reg [NELEM];
    logic signed [PROD_W-1:0] pb_reg [NELEM];
    logic signed [ELEM_W-1:0] a1_reg [NELEM];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NELEM; i++)
            begin
                pa_reg[i] <= PROD_W'(a_w[PA_L[i]]) * PROD_W'(a_w[PA_R[i]]);
                pb_reg[i] <= PROD_W'(a_w[PB_L[i]]) * PROD_W'(a_w[PB_R[i]]);
                a1_reg[i] <= a_w[i];
            end
        end
    end

    // Stage 2: cofactors, exact in Q17.16.
    logic signed [ADJ_W-1:0]  adj2_reg [NELEM];
    logic signed [ELEM_W-1:0] a2_reg   [NELEM];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NELEM; i++)
            begin
                adj2_reg[i] <= ADJ_W'(pa_reg[i]) - ADJ_W'(pb_reg[i]);
                a2_reg[i]   <= a1_reg[i];
            end
        end
    end

    // Stage 3: first-row expansion products, element (0,j) times
    // cofactor (j,0).
    logic signed [DP_W-1:0]   dp_reg   [3];
    logic signed [ADJ_W-1:0]  adj3_reg [NELEM];
    logic signed [ELEM_W-1:0] a3_reg   [NELEM];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
                dp_reg[j] <= DP_W'(a2_reg[j]) * DP_W'(adj2_reg[3*j]);
            adj3_reg <= adj2_reg;
            a3_reg   <= a2_reg;
        end
    end

    // Stage 4: determinant and all magnitudes.
    logic signed [DET_W-1:0] det_w;
    logic [DET_W-1:0]        dmag_reg;
    logic                    dneg_reg;
    logic [MAG_W-1:0]        amag_reg [NELEM];
    logic                    aneg_reg [NELEM];
    logic signed [ELEM_W-1:0] a4_reg  [NELEM];

    assign det_w = DET_W'(dp_reg[0]) + DET_W'(dp_reg[1]) + DET_W'(dp_reg[2]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dmag_reg <= det_w[DET_W-1] ? DET_W'(-det_w) : DET_W'(det_w);
            dneg_reg <= det_w[DET_W-1];
            for (int i = 0; i < NELEM; i++)
            begin
                amag_reg[i] <= adj3_reg[i][ADJ_W-1] ? MAG_W'(-adj3_reg[i])
                                                    : MAG_W'(adj3_reg[i]);
                aneg_reg[i] <= adj3_reg[i][ADJ_W-1];
            end
            a4_reg <= a3_reg;
        end
    end

    // Stage 5: tolerance compare and the early overflow test. A quotient
    // of 2^33 or more is known to saturate, which keeps the lanes to 33
    // quotient bits.
    logic      sing_w;
    mi3_lane_t lane_reg [NELEM];

    assign sing_w = {{(CMP_W-DET_W){1'b0}}, dmag_reg} <= {tol_reg, 8'h00};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NELEM; i++)
            begin
                lane_reg[i].mag  <= amag_reg[i];
                lane_reg[i].neg  <= aneg_reg[i] ^ dneg_reg;
                lane_reg[i].den  <= dmag_reg;
                lane_reg[i].ovf  <= {{(DET_W-TOP_W){1'b0}}, amag_reg[i][MAG_W-1:PRE_SH]}
                                    >= dmag_reg;
                lane_reg[i].sing <= sing_w;
                lane_reg[i].pass <= a4_reg[i];
            end
        end
    end

    // Divider lanes.
    logic signed [OUT_W-1:0] r_w   [NELEM];
    logic [NELEM-1:0]        inv_w;

    genvar g;
    generate
        for (g = 0; g < NELEM; g++)
        begin : g_lane
            mi3_div_lane u_lane (
                .clk     (clk),
                .en      (en),
                .lane_in (lane_reg[g]),
                .r       (r_w[g]),
                .inv     (inv_w[g])
            );
        end
    endgenerate

    assign r_00 = r_w[0];
    assign r_01 = r_w[1];
    assign r_02 = r_w[2];
    assign r_10 = r_w[3];
    assign r_11 = r_w[4];
    assign r_12 = r_w[5];
    assign r_20 = r_w[6];
    assign r_21 = r_w[7];
    assign r_22 = r_w[8];
    // Every lane carries the same singular flag.
    assign invertible = &inv_w;

    // A held pipeline keeps its valid bits where they are; three of them are checked.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> ($stable(vld_reg[0]) && $stable(vld_reg[FRONT]) && $stable(vld_reg[LAT-1])))
        else $error("valid bits moved while the pipeline was held");

    // The tolerance only changes through a write.
    a_tol: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(tol_reg) |-> $past(cfg_valid))
        else $error("tolerance changed without a write");

    // A zero determinant is always taken as singular.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (en && vld_reg[FRONT-2] && dmag_reg == '0) |=> lane_reg[0].sing)
        else $error("zero determinant not flagged singular");

    // All lanes agree on the singular flag.
    a_lanes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (inv_w == '0 || inv_w == '1))
        else $error("divider lanes disagree on the singular flag");

endmodule

>>> verif/matrix3x3_inverse_top_tb.sv
// ============================================================================
// matrix3x3_inverse_top_tb: self-checking bench for the 3x3 matrix inverse
// Drives matrices in bursts with random gaps and stalls the result word on
// its own pattern. A scoreboard predicts each result by adjugate, determinant
// and rounded saturating division, and checks every result word in order.
// ============================================================================
module matrix3x3_inverse_top_tb;
    import mi3_pkg::*;

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic signed [OUT_W-1:0]  res_t;

    typedef struct {
        res_t r [NELEM];
        logic inv;
    } inverse_t;

    // Scoreboard: holds the tolerance and the queue of predicted inverses.
    class inverse_scoreboard;
        logic [TOL_W-1:0] tolerance;
        inverse_t         pending [$];
        int               errors;

        function new();
            tolerance = TOL_RESET;
            errors    = 0;
        endfunction

        function res_t round_div(longint num, longint den);
            bit       neg;
            bit [63:0] n;
            bit [63:0] d;
            bit [63:0] q;
            neg = (num < 0) != (den < 0);
            n = (num < 0 ? -num : num);
            n = n << FRAC_SH;
            d = (den < 0 ? -den : den);
            q = (2 * n + d) / (2 * d);
            if (neg)
                return (q > 64'd2147483648) ? res_t'(32'h8000_0000) : res_t'(-longint'(q));
            return (q > 64'd2147483647) ? res_t'(32'h7FFF_FFFF) : res_t'(q);
        endfunction

        function void note_matrix(elem_t a [NELEM]);
            longint   m [3][3];
            longint   adj [3][3];
            longint   det;
            bit [63:0] mag;
            bit [63:0] lim;
            inverse_t e;
            for (int i = 0; i < 9; i++)
                m[i / 3][i % 3] = a[i];
            adj[0][0] = m[1][1] * m[2][2] - m[1][2] * m[2][1];
            adj[0][1] = m[0][2] * m[2][1] - m[0][1] * m[2][2];
            adj[0][2] = m[0][1] * m[1][2] - m[0][2] * m[1][1];
            adj[1][0] = m[1][2] * m[2][0] - m[1][0] * m[2][2];
            adj[1][1] = m[0][0] * m[2][2] - m[0][2] * m[2][0];
            adj[1][2] = m[0][2] * m[1][0] - m[0][0] * m[1][2];
            adj[2][0] = m[1][0] * m[2][1] - m[1][1] * m[2][0];
            adj[2][1] = m[0][1] * m[2][0] - m[0][0] * m[2][1];
            adj[2][2] = m[0][0] * m[1][1] - m[0][1] * m[1][0];
            det = m[0][0] * adj[0][0] + m[0][1] * adj[1][0] + m[0][2] * adj[2][0];
            mag = (det < 0) ? -det : det;
            lim = {17'd0, tolerance} << 8;
            e.inv = (mag > lim);
            for (int i = 0; i < 9; i++)
                e.r[i] = e.inv ? round_div(adj[i / 3][i % 3], det)
                               : res_t'(m[i / 3][i % 3] * 256);
            pending.push_back(e);
        endfunction

        function void check_result(res_t r [NELEM], logic inv);
            inverse_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result word", $time);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (inv !== e.inv)
            begin
                $display("%0t: invertible expected %0b actual %0b", $time, e.inv, inv);
                errors++;
            end
            for (int i = 0; i < 9; i++)
                if (r[i] !== e.r[i])
                begin
                    $display("%0t: r_%0d%0d expected %0d actual %0d",
                             $time, i / 3, i % 3, e.r[i], r[i]);
                    errors++;
                end
        endfunction
    endclass

    localparam int WATCHDOG = 20000;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    elem_t            a [NELEM];
    logic             out_valid;
    logic             out_stall = 1'b0;
    res_t             r [NELEM];
    logic             invertible;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [TOL_W-1:0] cfg_data = '0;

    inverse_scoreboard sb = new();
    int                idle_cycles = 0;
    bit                timed_out = 1'b0;
    int                stall_mode = 0;

    initial
        for (int i = 0; i < 9; i++)
            a[i] = '0;

    always #4 clk = ~clk;

    matrix3x3_inverse_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .a_00       (a[0]),
        .a_01       (a[1]),
        .a_02       (a[2]),
        .a_10       (a[3]),
        .a_11       (a[4]),
        .a_12       (a[5]),
        .a_20       (a[6]),
        .a_21       (a[7]),
        .a_22       (a[8]),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .r_00       (r[0]),
        .r_01       (r[1]),
        .r_02       (r[2]),
        .r_10       (r[3]),
        .r_11       (r[4]),
        .r_12       (r[5]),
        .r_20       (r[6]),
        .r_21       (r[7]),
        .r_22       (r[8]),
        .invertible (invertible),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    // Result side: check at each accepting edge, then choose the next stall
    // level. The stall pattern changes character at random so that long
    // unstalled runs sit beside heavy back-pressure.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(r, invertible);
        if ($urandom_range(0, 299) == 0)
            stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 1) == 0);
        endcase
    end

    // Watchdog: any accepted word on either side, a tolerance write or reset restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG && !timed_out)
        begin
            timed_out = 1'b1;
            $display("status: fail");
            $finish;
        end
    end

    // Offers one matrix and holds it until the block takes it.
    task automatic send_matrix(elem_t m [NELEM]);
        in_valid <= 1'b1;
        for (int i = 0; i < 9; i++)
            a[i] <= m[i];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_matrix(m);
    endtask

    task automatic pause_sender(int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Lets every expected word drain, then holds the input idle, before a write.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (LAT + 4) @(posedge clk);
    endtask

    task automatic write_tolerance(logic [TOL_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.tolerance = value;
        cfg_valid <= 1'b0;
    endtask

    function automatic elem_t rand_elem(int kind);
        case (kind)
            0: return elem_t'($urandom);
            1: return elem_t'($urandom_range(0, 1024)) - elem_t'(512);
            2: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            default: return elem_t'($urandom_range(0, 16)) - elem_t'(8);
        endcase
    endfunction

    // Random matrix of a chosen flavour: full-range noise, moderate values,
    // extremes, small integers, a diagonal matrix, or a deliberately
    // near-singular matrix in which the third row is the mean of the first
    // two plus a small nudge.
    function automatic void rand_matrix(output elem_t m [NELEM]);
        int kind;
        kind = $urandom_range(0, 5);
        for (int i = 0; i < 9; i++)
            m[i] = rand_elem(kind > 3 ? 1 : kind);
        if (kind == 5)
            for (int j = 0; j < 3; j++)
                m[6 + j] = (m[j] >>> 1) + (m[3 + j] >>> 1)
                           + elem_t'($urandom_range(0, 2)) - elem_t'(1);
        else if (kind == 4)
        begin
            for (int i = 0; i < 9; i++)
                m[i] = 0;
            for (int i = 0; i < 3; i++)
                m[i * 4] = rand_elem(1);
        end
    endfunction

    task automatic random_phase(int count);
        elem_t m [NELEM];
        int    burst;
        while (count > 0)
        begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && count > 0)
            begin
                rand_matrix(m);
                send_matrix(m);
                burst--;
                count--;
            end
            if ($urandom_range(0, 2) != 0)
                pause_sender($urandom_range(1, 12));
        end
    endtask

    task automatic directed_phase();
        elem_t m [NELEM];
        // Identity: exact inverse of one.
        m = '{16'sh0100, 0, 0, 0, 16'sh0100, 0, 0, 0, 16'sh0100};
        send_matrix(m);
        // All zero: determinant zero, always passed through.
        m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
        send_matrix(m);
        // Smallest nonzero diagonal: determinant of one LSB, below the reset
        // tolerance but above a tolerance of zero.
        m = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
        send_matrix(m);
        // Determinant of two LSBs: singular at the reset tolerance, and an
        // exact inverse once the tolerance is zero.
        m = '{2, 0, 0, 0, 1, 0, 0, 0, 1};
        send_matrix(m);
        m = '{-2, 0, 0, 0, 1, 0, 0, 0, 1};
        send_matrix(m);
        // Extremes of every field.
        m = '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
              16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF};
        send_matrix(m);
        m = '{16'sh8000, 0, 0, 0, 16'sh8000, 0, 0, 0, 16'sh8000};
        send_matrix(m);
        m = '{16'sh7FFF, 0, 0, 0, 16'sh7FFF, 0, 0, 0, 16'sh7FFF};
        send_matrix(m);
        m = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};
        send_matrix(m);
        // Negative diagonal and an inexact quotient (inverse of three).
        m = '{16'shFF00, 0, 0, 0, 16'sh0300, 0, 0, 0, 16'sh0200};
        send_matrix(m);
        // Full-rank general matrix with mixed signs.
        m = '{16'sh0200, 16'shFF00, 0, 16'shFF00, 16'sh0200, 16'shFF00,
              0, 16'shFF00, 16'sh0200};
        send_matrix(m);
        // Rank-two matrix: singular with nonzero entries.
        m = '{16'sh0100, 16'sh0200, 16'sh0300, 16'sh0400, 16'sh0500,
              16'sh0600, 16'sh0700, 16'sh0800, 16'sh0900};
        send_matrix(m);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_phase();
        random_phase(400);
        drain();

        // Tolerance zero: only an exactly zero determinant is singular.
        write_tolerance('0);
        directed_phase();
        random_phase(350);
        drain();

        // Maximum tolerance: every matrix counts as singular.
        write_tolerance({TOL_W{1'b1}});
        random_phase(150);
        drain();

        // Middling tolerances around the determinants of moderate matrices.
        write_tolerance(47'h0000_0001_0000);
        directed_phase();
        random_phase(350);
        drain();

        write_tolerance(TOL_W'($urandom_range(0, 32'h7FFF_FFFF)) << $urandom_range(0, 16));
        random_phase(350);
        drain();

        write_tolerance(TOL_W'({$urandom, $urandom}));
        random_phase(300);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/mi3_pkg.sv
hw/rtl/mi3_div_lane.sv
hw/rtl/matrix3x3_inverse_top.sv
verif/matrix3x3_inverse_top_tb.sv
